[hw/rtl/tmon_pkg.sv]
// Shared types and constants for the temperature run monitor.
// No dependencies; imported by the top level and its checker.
package tmon_pkg;

    localparam int TEMP_W    = 21;
    localparam int SUM_W     = 29;
    localparam int COUNT_W   = 8;
    localparam int CONSEC_W  = 4;
    localparam int PCT_W     = 14;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_TEMP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_READINGS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIP_COUNT   = 2'd2;

    localparam logic signed [TEMP_W-1:0] LIMIT_RESET = '0;
    localparam logic [COUNT_W-1:0]       MAX_RESET   = 8'd20;
    localparam logic [CONSEC_W-1:0]      TRIP_RESET  = 4'd3;

    localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;
    localparam logic [CONSEC_W-1:0] CONSEC_MAX = '1;

    // Percentage scale: hundredths of a percent.
    localparam logic [PCT_W-1:0] PCT_SCALE = 14'd10000;
    localparam int PROD_W = COUNT_W + PCT_W;

    // Result kinds.
    localparam logic KIND_READING = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    // Shared divider: one quotient bit per cycle over the widest dividend.
    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_READING,
        ST_LOAD_MEAN,
        ST_DIV_MEAN,
        ST_LOAD_PCT,
        ST_DIV_PCT,
        ST_REPORT
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic update;
        logic load_read;
        logic load_mean;
        logic div_step;
        logic load_pct;
        logic load_report;
    } t_ctrl;

endpackage

[hw/rtl/temperature_run_monitor.sv]
// Temperature run monitor: per-run statistics with an end-of-run report.
// Depends on tmon_pkg for widths, state and control types.

// A sample that does not end its run passes through capture, statistics update
// and the reading word, which waits while the output register is still held. A
// sample that ends the run adds the report, whose mean and percentage come out
// of one shared restoring divider producing a quotient bit per cycle: 29 steps
// for the mean and 29 for the percentage, plus load and report states. The block
// is not ready while a sample is in work; the output register lets the next word
// be prepared while the previous one waits.
module temperature_run_monitor
    import tmon_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [TEMP_W-1:0]          i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [TEMP_W-1:0]   i_sample_temp,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_result_kind,
    output logic [COUNT_W-1:0]         o_reading_index,
    output logic                       o_above_limit,
    output logic [CONSEC_W-1:0]        o_consecutive,
    output logic                       o_stop_reason,
    output logic signed [TEMP_W-1:0]   o_mean_temp,
    output logic signed [TEMP_W-1:0]   o_highest_temp,
    output logic signed [TEMP_W-1:0]   o_lowest_temp,
    output logic [COUNT_W-1:0]         o_over_count,
    output logic [PCT_W-1:0]           o_over_percent,
    output logic                       o_last_item
);

    t_state r_state, n_state;
    t_ctrl  ctrl;

    // Configuration.
    logic signed [TEMP_W-1:0] r_limit;
    logic [COUNT_W-1:0]       r_max;
    logic [CONSEC_W-1:0]      r_trip_count;

    // Run statistics.
    logic signed [SUM_W-1:0]  r_sum, n_sum;
    logic [COUNT_W-1:0]       r_count, n_count;
    logic signed [TEMP_W-1:0] r_high, n_high;
    logic signed [TEMP_W-1:0] r_low, n_low;
    logic [COUNT_W-1:0]       r_over, n_over;
    logic [CONSEC_W-1:0]      r_consec, n_consec;

    logic signed [TEMP_W-1:0] r_sample;
    logic r_above, n_above;
    logic r_trip, n_trip;
    logic r_done, n_done;

    // Shared divider.
    logic [SUM_W-1:0]     r_quot, n_quot;
    logic [COUNT_W-1:0]   r_rem, n_rem;
    logic [COUNT_W:0]     rem_shift;
    logic [DIV_CNT_W-1:0] r_step;
    logic                 div_last;
    logic                 r_neg;
    logic [SUM_W-1:0]     sum_mag;
    logic [PROD_W-1:0]    pct_prod;
    logic signed [TEMP_W-1:0] r_mean;

    // Output register.
    logic r_out_valid;
    logic out_free;
    logic                     r_kind, r_above_o, r_stop, r_last;
    logic [COUNT_W-1:0]       r_index, r_over_o;
    logic [CONSEC_W-1:0]      r_consec_o;
    logic signed [TEMP_W-1:0] r_mean_o, r_high_o, r_low_o;
    logic [PCT_W-1:0]         r_pct_o;

    assign out_free = !r_out_valid || i_out_ready;
    assign div_last = (r_step == DIV_CNT_W'(DIV_STEPS - 1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:      if (i_in_valid) n_state = ST_UPDATE;
            ST_UPDATE:    n_state = ST_READING;
            ST_READING:   if (out_free) n_state = r_done ? ST_LOAD_MEAN : ST_IDLE;
            ST_LOAD_MEAN: n_state = ST_DIV_MEAN;
            ST_DIV_MEAN:  if (div_last) n_state = ST_LOAD_PCT;
            ST_LOAD_PCT:  n_state = ST_DIV_PCT;
            ST_DIV_PCT:   if (div_last) n_state = ST_REPORT;
            ST_REPORT:    if (out_free) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // Control decode.
    always_comb begin
        ctrl = '0;
        case (r_state)
            ST_IDLE:      ctrl.in_ready = 1'b1;
            ST_UPDATE:    ctrl.update = 1'b1;
            ST_READING:   ctrl.load_read = out_free;
            ST_LOAD_MEAN: ctrl.load_mean = 1'b1;
            ST_DIV_MEAN:  ctrl.div_step = 1'b1;
            ST_LOAD_PCT:  ctrl.load_pct = 1'b1;
            ST_DIV_PCT:   ctrl.div_step = 1'b1;
            ST_REPORT:    ctrl.load_report = out_free;
            default:      ctrl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit      <= LIMIT_RESET;
            r_max        <= MAX_RESET;
            r_trip_count <= TRIP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LIMIT_TEMP:   r_limit      <= i_cfg_data;
                CFG_MAX_READINGS: r_max        <= i_cfg_data[COUNT_W-1:0];
                CFG_TRIP_COUNT:   r_trip_count <= i_cfg_data[CONSEC_W-1:0];
                default:          r_limit      <= r_limit;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.in_ready && i_in_valid) begin
            r_sample <= i_sample_temp;
        end
    end

    // Statistics update for the captured sample.
    always_comb begin
        n_sum   = r_sum + SUM_W'(r_sample);
        n_count = (r_count != COUNT_MAX) ? r_count + 1'b1 : r_count;
        n_above = r_sample > r_limit;
        if (n_count == COUNT_W'(1)) begin
            n_high = r_sample;
            n_low  = r_sample;
        end else begin
            n_high = (r_sample > r_high) ? r_sample : r_high;
            n_low  = (r_sample < r_low)  ? r_sample : r_low;
        end
        if (n_above) begin
            n_over   = (r_over != COUNT_MAX) ? r_over + 1'b1 : r_over;
            n_consec = (r_consec != CONSEC_MAX) ? r_consec + 1'b1 : r_consec;
        end else begin
            n_over   = r_over;
            n_consec = '0;
        end
        n_trip = n_consec >= r_trip_count;
        n_done = n_trip || (n_count >= r_max);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || ctrl.load_report) begin
            r_sum    <= '0;
            r_count  <= '0;
            r_high   <= '0;
            r_low    <= '0;
            r_over   <= '0;
            r_consec <= '0;
            r_above  <= 1'b0;
            r_trip   <= 1'b0;
            r_done   <= 1'b0;
        end else if (ctrl.update) begin
            r_sum    <= n_sum;
            r_count  <= n_count;
            r_high   <= n_high;
            r_low    <= n_low;
            r_over   <= n_over;
            r_consec <= n_consec;
            r_above  <= n_above;
            r_trip   <= n_trip;
            r_done   <= n_done;
        end
    end

    // Divider step: shift in the next dividend bit, subtract when it fits.
    assign sum_mag  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign pct_prod = PROD_W'(r_over) * PROD_W'(PCT_SCALE);
    assign rem_shift = {r_rem, r_quot[SUM_W-1]};

    always_comb begin
        if (rem_shift >= {1'b0, r_count}) begin
            n_rem  = COUNT_W'(rem_shift - {1'b0, r_count});
            n_quot = {r_quot[SUM_W-2:0], 1'b1};
        end else begin
            n_rem  = rem_shift[COUNT_W-1:0];
            n_quot = {r_quot[SUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.load_mean) begin
            r_quot <= sum_mag;
            r_rem  <= '0;
            r_step <= '0;
            r_neg  <= r_sum[SUM_W-1];
        end else if (ctrl.load_pct) begin
            r_quot <= SUM_W'(pct_prod);
            r_rem  <= '0;
            r_step <= '0;
            // The mean quotient is final here; restore its sign.
            r_mean <= r_neg ? -r_quot[TEMP_W-1:0] : r_quot[TEMP_W-1:0];
        end else if (ctrl.div_step) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
            r_step <= r_step + 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.load_read || ctrl.load_report) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.load_read) begin
            r_kind     <= KIND_READING;
            r_index    <= r_count;
            r_above_o  <= r_above;
            r_consec_o <= r_consec;
            r_stop     <= 1'b0;
            r_mean_o   <= '0;
            r_high_o   <= '0;
            r_low_o    <= '0;
            r_over_o   <= '0;
            r_pct_o    <= '0;
            r_last     <= !r_done;
        end else if (ctrl.load_report) begin
            r_kind     <= KIND_REPORT;
            r_index    <= r_count;
            r_above_o  <= 1'b0;
            r_consec_o <= r_consec;
            r_stop     <= r_trip;
            r_mean_o   <= r_mean;
            r_high_o   <= r_high;
            r_low_o    <= r_low;
            r_over_o   <= r_over;
            r_pct_o    <= r_quot[PCT_W-1:0];
            r_last     <= 1'b1;
        end
    end

    assign o_in_ready      = ctrl.in_ready;
    assign o_out_valid     = r_out_valid;
    assign o_result_kind   = r_kind;
    assign o_reading_index = r_index;
    assign o_above_limit   = r_above_o;
    assign o_consecutive   = r_consec_o;
    assign o_stop_reason   = r_stop;
    assign o_mean_temp     = r_mean_o;
    assign o_highest_temp  = r_high_o;
    assign o_lowest_temp   = r_low_o;
    assign o_over_count    = r_over_o;
    assign o_over_percent  = r_pct_o;
    assign o_last_item     = r_last;

endmodule

[hw/rtl/tmon_checker.sv]
// Port-level checks for the temperature run monitor, bound to the top level.
// Depends on tmon_pkg for field widths and result kinds.
module tmon_checker
    import tmon_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_ready,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic                     o_result_kind,
    input logic [COUNT_W-1:0]       o_reading_index,
    input logic signed [TEMP_W-1:0] o_mean_temp,
    input logic signed [TEMP_W-1:0] o_highest_temp,
    input logic signed [TEMP_W-1:0] o_lowest_temp,
    input logic [COUNT_W-1:0]       o_over_count,
    input logic                     o_last_item
);

    // A sample keeps the block busy for at least the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted on two consecutive cycles");

    // A stalled word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_result_kind) && $stable(o_reading_index)
            && $stable(o_mean_temp) && $stable(o_last_item))
        else $error("stalled output word changed");

    // A report is always the last word of its sample.
    a_report_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind == KIND_REPORT) |-> o_last_item)
        else $error("report without last flag");

    // Report statistics are consistent with each other.
    a_report_stats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind == KIND_REPORT) |->
            (o_lowest_temp <= o_highest_temp) && (o_over_count <= o_reading_index)
            && (o_mean_temp >= o_lowest_temp) && (o_mean_temp <= o_highest_temp))
        else $error("inconsistent report statistics");

endmodule

bind temperature_run_monitor tmon_checker u_tmon_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_result_kind   (o_result_kind),
    .o_reading_index (o_reading_index),
    .o_mean_temp     (o_mean_temp),
    .o_highest_temp  (o_highest_temp),
    .o_lowest_temp   (o_lowest_temp),
    .o_over_count    (o_over_count),
    .o_last_item     (o_last_item)
);
